// ===== design/spq_pkg.sv =====
// Shared types, constants and codes of the sorted priority queue.
// No dependencies; every other design file refers to it by scoped names.
package spq_pkg;

  // Store depth and kept priority width
  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 8;
  localparam int PRIO_W    = (PRIO_BITS < 8) ? PRIO_BITS : 8;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Capacity register reset value
  localparam logic [4:0] QSIZE_RST = 5'd16;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PRIO_W-1:0] kprio_t;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] entry_prio;
    logic [7:0] entry_char;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_prio;
    logic [7:0] out_char;
    status_t    status;
    logic [4:0] entry_count;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the accepted input beat
    logic exec;  // apply the operation and load the result register
  } dp_cmd_t;

endpackage

// ===== design/spq_ctrl.sv =====
// Controller of the sorted priority queue: handshakes and sequencing.
// Depends on spq_pkg; drives spq_dp through a command struct.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::dp_cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      spq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/spq_dp.sv =====
// Datapath of the sorted priority queue: sorted slot row with one
// comparator per slot, capacity register and result register. Uses spq_pkg.
module spq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_pkg::dp_cmd_t    cmd,
  input  spq_pkg::in_beat_t   in_data,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  output spq_pkg::out_beat_t  out_data
);

  localparam int D = spq_pkg::DEPTH;

  spq_pkg::in_beat_t  req_r;
  spq_pkg::out_beat_t res_r, res_nxt;
  logic [4:0]         qsize_r;
  spq_pkg::cnt_t      count_r, count_nxt;

  // Slot 0 is always the head; entries stay sorted by index
  spq_pkg::kprio_t slot_prio_r [D];
  logic [7:0]      slot_char_r [D];
  spq_pkg::kprio_t slot_prio_nxt [D];
  logic [7:0]      slot_char_nxt [D];

  // Neighbor views of the row
  spq_pkg::kprio_t lo_prio [D];
  logic [7:0]      lo_char [D];
  spq_pkg::kprio_t hi_prio [D];
  logic [7:0]      hi_char [D];

  logic [D:0]      gt_ext;
  spq_pkg::kprio_t new_prio;
  spq_pkg::cnt_t   cap;
  logic            full, empty;

  for (genvar g = 0; g < D; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign lo_prio[g] = '0;
      assign lo_char[g] = '0;
    end else begin : g_mid
      assign lo_prio[g] = slot_prio_r[g-1];
      assign lo_char[g] = slot_char_r[g-1];
    end
    if (g == D - 1) begin : g_last
      assign hi_prio[g] = slot_prio_r[g];
      assign hi_char[g] = slot_char_r[g];
    end else begin : g_inner
      assign hi_prio[g] = slot_prio_r[g+1];
      assign hi_char[g] = slot_char_r[g+1];
    end
  end

  // Clamp capacity to 1..DEPTH
  always_comb begin
    if (qsize_r == 5'd0) begin
      cap = spq_pkg::cnt_t'(1);
    end else if (32'(qsize_r) > D) begin
      cap = spq_pkg::cnt_t'(D);
    end else begin
      cap = spq_pkg::cnt_t'(qsize_r);
    end
  end

  assign full     = (count_r >= cap);
  assign empty    = (count_r == '0);
  assign new_prio = req_r.entry_prio[spq_pkg::PRIO_W-1:0];

  // Per-slot compare: held entry sorts after the new one
  always_comb begin
    gt_ext[0] = 1'b0;
    for (int i = 0; i < D; i++) begin
      gt_ext[i+1] = (spq_pkg::cnt_t'(i) < count_r) && (slot_prio_r[i] > new_prio);
    end
  end

  // Next row, count and result
  always_comb begin
    count_nxt           = count_r;
    res_nxt             = '0;
    res_nxt.status      = spq_pkg::STAT_ENQ;
    for (int i = 0; i < D; i++) begin
      slot_prio_nxt[i] = slot_prio_r[i];
      slot_char_nxt[i] = slot_char_r[i];
    end
    if (req_r.op == spq_pkg::OP_ENQ) begin
      if (full) begin
        res_nxt.status = spq_pkg::STAT_FULL;
      end else begin
        // Shift larger entries up one slot, drop the new one into the gap
        for (int i = 0; i < D; i++) begin
          if (gt_ext[i]) begin
            slot_prio_nxt[i] = lo_prio[i];
            slot_char_nxt[i] = lo_char[i];
          end else if (gt_ext[i+1] || spq_pkg::cnt_t'(i) == count_r) begin
            slot_prio_nxt[i] = new_prio;
            slot_char_nxt[i] = req_r.entry_char;
          end
        end
        count_nxt = count_r + spq_pkg::cnt_t'(1);
      end
    end else begin
      if (empty) begin
        res_nxt.status = spq_pkg::STAT_EMPTY;
      end else begin
        // Report the head and advance the row down one slot
        res_nxt.out_prio = 8'(slot_prio_r[0]);
        res_nxt.out_char = slot_char_r[0];
        res_nxt.status   = spq_pkg::STAT_DEQ;
        for (int i = 0; i < D; i++) begin
          slot_prio_nxt[i] = hi_prio[i];
          slot_char_nxt[i] = hi_char[i];
        end
        count_nxt = count_r - spq_pkg::cnt_t'(1);
      end
    end
    res_nxt.entry_count = 5'(count_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      qsize_r <= spq_pkg::QSIZE_RST;
    end else begin
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        qsize_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < D; i++) begin
        slot_prio_r[i] <= slot_prio_nxt[i];
        slot_char_r[i] <= slot_char_nxt[i];
      end
    end
  end

  assign out_data = res_r;

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: ties controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Bounded priority queue of up to 16 (priority, character) entries, kept
// sorted with the smallest priority at the head; equal priorities leave in
// arrival order. Each input beat (enqueue or dequeue) yields one result beat
// with the dequeued entry, a status code and the entry count. A beat is
// captured; once the result register is free, a comparator per slot shifts
// the sorted slot row and the result register is loaded. No new beat is
// taken before the last has executed. A pending result does not block the
// next input beat. The capacity register is to be written through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce
// this. Zero counts as one, values above 16 as 16.
module sorted_priority_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spq_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spq_pkg::out_beat_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);

  spq_pkg::dp_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top.
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_beat_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Each accepted beat makes the block busy, so inputs are not taken back to back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // Only a real dequeue carries entry data
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != spq_pkg::STAT_DEQ |->
      out_data.out_prio == 8'd0 && out_data.out_char == 8'd0)
    else $error("nonzero entry data without a dequeue");

  // Count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.entry_count) <= spq_pkg::DEPTH)
    else $error("entry count beyond depth");

  // Rejected empty dequeue reports an empty queue
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spq_pkg::STAT_EMPTY |-> out_data.entry_count == 5'd0)
    else $error("empty rejection with entries held");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/sorted_priority_queue_top_test.sv =====
// Self-checking bench for sorted_priority_queue_top: directed rows, then random phases.
// A shadow sorted store predicts each result beat. Depends on spq_pkg and the design files.
module sorted_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DIR_N     = 24;
  localparam int N_PHASES  = 9;
  localparam int LONG_HOLD = 120;
  localparam int STALL_MAX = 1000;
  localparam int TAIL_WAIT = 8;

  // One directed row: either a capacity write or an operation beat
  typedef struct packed {
    logic       is_cfg;
    logic [4:0] cap_val;
    logic       typed;
    in_beat_t   beat;
    out_beat_t  want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_data;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  // Shadow copy of the sorted store and the capacity register
  int         sh_prio [DEPTH];
  logic [7:0] sh_char [DEPTH];
  int         sh_head;
  int         sh_count;
  logic [4:0] sh_cap;

  out_beat_t  due_results [$];
  int         mismatches = 0;
  int         stall_cycles = 0;
  bit         tx_idle;
  bit         rx_idle;
  bit         rx_long_hold;
  stim_row_t  dir_tab [DIR_N];
  int         phase_cap [N_PHASES];
  int         phase_len [N_PHASES];

  sorted_priority_queue_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow store and return the result beat
  function automatic out_beat_t apply_queue_op(in_beat_t b);
    out_beat_t r;
    int        cap;
    int        k;
    int        p;
    r   = '0;
    cap = (sh_cap < 1) ? 1 : ((sh_cap > DEPTH) ? DEPTH : int'(sh_cap));
    p   = int'(b.entry_prio) & ((1 << PRIO_BITS) - 1);
    if (b.op == OP_ENQ) begin
      if (sh_count >= cap) begin
        r.status = STAT_FULL;
      end else begin
        // shift larger priorities one slot toward the tail
        k = sh_count;
        while (k > 0 && sh_prio[(sh_head + k - 1) % DEPTH] > p) begin
          sh_prio[(sh_head + k) % DEPTH] = sh_prio[(sh_head + k - 1) % DEPTH];
          sh_char[(sh_head + k) % DEPTH] = sh_char[(sh_head + k - 1) % DEPTH];
          k--;
        end
        sh_prio[(sh_head + k) % DEPTH] = p;
        sh_char[(sh_head + k) % DEPTH] = b.entry_char;
        sh_count++;
        r.status = STAT_ENQ;
      end
    end else if (sh_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.out_prio = sh_prio[sh_head][7:0];
      r.out_char = sh_char[sh_head];
      sh_count--;
      sh_head  = (sh_count == 0) ? 0 : (sh_head + 1) % DEPTH;
      r.status = STAT_DEQ;
    end
    r.entry_count = sh_count[4:0];
    return r;
  endfunction

  function automatic stim_row_t beat_row(logic op, logic [7:0] p, logic [7:0] c);
    stim_row_t r;
    r = '0;
    r.beat.op         = op;
    r.beat.entry_prio = p;
    r.beat.entry_char = c;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [4:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cap_val = v;
    return r;
  endfunction

  function automatic stim_row_t with_result(stim_row_t r, logic [7:0] p, logic [7:0] c,
                                            status_t st, logic [4:0] cnt);
    stim_row_t t;
    t = r;
    t.typed            = 1'b1;
    t.want.out_prio    = p;
    t.want.out_char    = c;
    t.want.status      = st;
    t.want.entry_count = cnt;
    return t;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat after a random gap when tx_idle is set, then record its expected result
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    int        gap;
    out_beat_t due;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = apply_queue_op(b);
    if (typed) due = want;
    due_results.push_back(due);
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has drained
  task automatic settle_queue();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] v);
    settle_queue();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sh_cap = v;
  endtask

  // Random beat: bias the op mix, crowd priorities to force ties
  function automatic in_beat_t random_beat(int enq_pct);
    in_beat_t b;
    b.op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    case ($urandom_range(0, 3))
      0: b.entry_prio = 8'($urandom_range(0, 255));
      1: b.entry_prio = 8'($urandom_range(0, 3));
      2: b.entry_prio = 8'($urandom_range(252, 255));
      default: b.entry_prio = 8'($urandom_range(100, 103));
    endcase
    b.entry_char = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Result sink: random stall per beat when rx_idle is set, plus one long hold on request
  initial begin : result_sink
    int gap;
    bit long_done;
    out_ready = 1'b0;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_long_hold && !long_done) begin
        gap = LONG_HOLD;
        long_done = 1'b1;
      end else begin
        gap = rx_idle ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    out_beat_t due;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, got prio %0d char %0d status %0d count %0d",
                 $time, out_data.out_prio, out_data.out_char, out_data.status,
                 out_data.entry_count);
        mismatches++;
      end else begin
        due = due_results.pop_front();
        check_field("out_prio", due.out_prio, out_data.out_prio);
        check_field("out_char", due.out_char, out_data.out_char);
        check_field("status", 8'(due.status), 8'(out_data.status));
        check_field("entry_count", 8'(due.entry_count), 8'(out_data.entry_count));
      end
    end
  end

  // Watchdog: count cycles with no beat on either side and no register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : main_seq
    int        enq_pct;
    in_beat_t  b;
    out_beat_t nothing;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_long_hold = 1'b0;
    nothing      = '0;
    sh_head      = 0;
    sh_count     = 0;
    sh_cap       = QSIZE_RST;
    foreach (sh_prio[i]) begin
      sh_prio[i] = 0;
      sh_char[i] = '0;
    end

    // Directed rows: empty/full rejects, capacity clamps, ties, lowered capacity
    dir_tab = '{
      with_result(beat_row(OP_DEQ, 8'h00, 8'h00), 8'h00, 8'h00, STAT_EMPTY, 5'd0),
      cfg_row(5'd0),
      with_result(beat_row(OP_ENQ, 8'h80, 8'hAA), 8'h00, 8'h00, STAT_ENQ, 5'd1),
      with_result(beat_row(OP_ENQ, 8'h10, 8'h11), 8'h00, 8'h00, STAT_FULL, 5'd1),
      cfg_row(5'd3),
      beat_row(OP_ENQ, 8'hFF, 8'hFF),
      beat_row(OP_ENQ, 8'h00, 8'h00),
      with_result(beat_row(OP_ENQ, 8'h01, 8'h01), 8'h00, 8'h00, STAT_FULL, 5'd3),
      cfg_row(5'd1),
      with_result(beat_row(OP_ENQ, 8'h20, 8'h20), 8'h00, 8'h00, STAT_FULL, 5'd3),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      cfg_row(5'd31),
      beat_row(OP_ENQ, 8'h80, 8'h01),
      beat_row(OP_ENQ, 8'h80, 8'h02),
      beat_row(OP_ENQ, 8'h7F, 8'h55),
      beat_row(OP_ENQ, 8'h81, 8'h00),
      beat_row(OP_DEQ, 8'hFF, 8'hFF),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      beat_row(OP_DEQ, 8'h00, 8'h00),
      with_result(beat_row(OP_DEQ, 8'h00, 8'h00), 8'h00, 8'h00, STAT_EMPTY, 5'd0),
      cfg_row(5'd16)
    };

    phase_cap = '{16, 31, 0, 2, $urandom_range(3, 15), 16, $urandom_range(17, 30), 1, 16};
    phase_len = '{200, 150, 100, 100, 200, 150, 150, 50, 150};

    // Hold reset low, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_capacity(dir_tab[i].cap_val);
      end else begin
        send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases, each under its own capacity and idle pattern
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_capacity(5'(phase_cap[ph]));
      tx_idle = (ph != 1) && (ph != 5);
      rx_idle = (ph != 1);
      if (ph == 5) rx_long_hold = 1'b1;
      enq_pct = 50;
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 20;
            1: enq_pct = 50;
            default: enq_pct = 80;
          endcase
        end
        b = random_beat(enq_pct);
        send_beat(b, 1'b0, nothing);
      end
    end

    // Drain and let any late beat show up
    settle_queue();
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue_top.f =====
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
bench/sorted_priority_queue_top_test.sv
